### src/presence_table_with_slot_pool_core_macros.svh
// Assertion macros shared by the presence table checker.
`ifndef PRESENCE_TABLE_WITH_SLOT_POOL_CORE_MACROS_SVH
`define PRESENCE_TABLE_WITH_SLOT_POOL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("presence table check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("presence table check failed");

`endif

### src/pt_pkg.sv
// Shared types and constants of the presence table.
package pt_pkg;

	localparam int USER_COUNT_DEF = 131072;
	localparam int SLOT_COUNT_DEF = 128;

	localparam logic [1:0] OP_OFFLINE = 2'd0;
	localparam logic [1:0] OP_ONLINE  = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	localparam logic [2:0] RC_OK      = 3'd0;
	localparam logic [2:0] RC_RANGE   = 3'd1;
	localparam logic [2:0] RC_ONLINE  = 3'd2;
	localparam logic [2:0] RC_OFFLINE = 3'd3;
	localparam logic [2:0] RC_FULL    = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_IPRD
	} pt_state_t;

	typedef struct packed {
		logic [31:0] ip;
		logic        online;
		logic [2:0]  rc;
	} pt_result_t;

endpackage

### src/pt_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module pt_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/pt_ctrl.sv
// Sequencer of the presence table: clear sweep, map lookup, pool update, result register.
module pt_ctrl #(
	parameter int USER_COUNT = pt_pkg::USER_COUNT_DEF,
	parameter int SLOT_COUNT = pt_pkg::SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_op,
	input  logic [31:0]                   s_uid,
	input  logic [31:0]                   s_ip,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output pt_pkg::pt_result_t            m_res,
	output logic                          map_we,
	output logic [$clog2(USER_COUNT)-1:0] map_waddr,
	output logic [$clog2(SLOT_COUNT):0]   map_wdata,
	output logic                          map_re,
	output logic [$clog2(USER_COUNT)-1:0] map_raddr,
	input  logic [$clog2(SLOT_COUNT):0]   map_rdata,
	output logic                          ring_we,
	output logic [$clog2(SLOT_COUNT)-1:0] ring_waddr,
	output logic [$clog2(SLOT_COUNT)-1:0] ring_wdata,
	output logic                          ring_re,
	output logic [$clog2(SLOT_COUNT)-1:0] ring_raddr,
	input  logic [$clog2(SLOT_COUNT)-1:0] ring_rdata,
	output logic                          ip_we,
	output logic [$clog2(SLOT_COUNT)-1:0] ip_waddr,
	output logic [31:0]                   ip_wdata,
	output logic                          ip_re,
	output logic [$clog2(SLOT_COUNT)-1:0] ip_raddr,
	input  logic [31:0]                   ip_rdata
);

	import pt_pkg::*;

	localparam int USER_W = $clog2(USER_COUNT);
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int CLR_N  = (USER_COUNT > SLOT_COUNT) ? USER_COUNT : SLOT_COUNT;
	localparam int CLR_W  = $clog2(CLR_N);

	pt_state_t         state_q, state_d;
	logic [CLR_W-1:0]  clr_q;
	logic [1:0]        op_q;
	logic [USER_W-1:0] uid_q;
	logic [31:0]       ip_q;
	logic              range_q;
	logic [SLOT_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              take, push, load, out_free;
	logic              map_v;
	logic [SLOT_W-1:0] map_slot;
	logic              clr_in_map, clr_in_ring;
	pt_result_t        res_d;

	function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
		ring_next = (p == SLOT_W'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
	endfunction

	assign map_v       = map_rdata[SLOT_W];
	assign map_slot    = map_rdata[SLOT_W-1:0];
	assign out_free    = !m_tvalid || m_tready;
	assign clr_in_map  = {1'b0, clr_q} < (CLR_W + 1)'(USER_COUNT);
	assign clr_in_ring = {1'b0, clr_q} < (CLR_W + 1)'(SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		map_we     = 1'b0;
		map_waddr  = uid_q;
		map_wdata  = '0;
		map_re     = 1'b0;
		map_raddr  = s_uid[USER_W-1:0];
		ring_we    = 1'b0;
		ring_waddr = tail_q;
		ring_wdata = map_slot;
		ring_re    = 1'b0;
		ring_raddr = head_q;
		ip_we      = 1'b0;
		ip_waddr   = ring_rdata;
		ip_wdata   = ip_q;
		ip_re      = 1'b0;
		ip_raddr   = map_slot;
		take       = 1'b0;
		push       = 1'b0;
		load       = 1'b0;
		res_d      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				map_we     = clr_in_map;
				map_waddr  = clr_q[USER_W-1:0];
				ring_we    = clr_in_ring;
				ring_waddr = clr_q[SLOT_W-1:0];
				ring_wdata = clr_q[SLOT_W-1:0];
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					map_re  = 1'b1;
					ring_re = 1'b1;
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				if (!range_q && op_q != OP_OFFLINE && op_q != OP_ONLINE && map_v) begin
					ip_re   = 1'b1;
					state_d = ST_IPRD;
				end else if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					if (range_q) begin
						res_d.rc = RC_RANGE;
					end else begin
						case (op_q)
							OP_ONLINE: begin
								if (map_v) begin
									res_d.rc = RC_ONLINE;
								end else if (cnt_q == '0) begin
									res_d.rc = RC_FULL;
								end else begin
									map_we    = 1'b1;
									map_wdata = {1'b1, ring_rdata};
									ip_we     = 1'b1;
									take      = 1'b1;
								end
							end
							OP_OFFLINE: begin
								if (!map_v) begin
									res_d.rc = RC_OFFLINE;
								end else begin
									map_we = 1'b1;
									if (cnt_q < CNT_W'(SLOT_COUNT)) begin
										ring_we = 1'b1;
										push    = 1'b1;
									end
								end
							end
							default: begin
								res_d.rc = RC_OK;
							end
						endcase
					end
				end
			end
			ST_IPRD: begin
				if (out_free) begin
					load         = 1'b1;
					res_d.rc     = RC_OK;
					res_d.online = 1'b1;
					res_d.ip     = ip_rdata;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= CNT_W'(SLOT_COUNT);
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (take) begin
				head_q <= ring_next(head_q);
				cnt_q  <= cnt_q - 1'b1;
			end else if (push) begin
				tail_q <= ring_next(tail_q);
				cnt_q  <= cnt_q + 1'b1;
			end
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_q    <= s_op;
			uid_q   <= s_uid[USER_W-1:0];
			ip_q    <= s_ip;
			range_q <= s_uid >= 32'(USER_COUNT);
		end
		if (load) begin
			m_res <= res_d;
		end
	end

endmodule

### src/presence_table_with_slot_pool_core.sv
// Top level of the presence table with its slot pool.
// Input channel s_axis: one request per item. tuser carries the op
// (offline, online, query; the unused code acts as a query), tdata the user
// id and the server address. Output channel m_axis: one result per item with
// result code, online flag and stored address.
// Status changes and failed lookups load their result in the map state; a
// query of an online user first passes the slot address read state, since
// that read needs the slot index that the map read returns. The next item is
// accepted the cycle after its predecessor's result is loaded, so one item
// runs at a time. After reset the block sweeps the user map and the free
// slot ring, one entry a cycle, with s_axis_tready low. A finished result
// waits in the output register while the next item is accepted; if the
// receiver still stalls when that item's result is ready, the block holds
// it and takes no further item.
module presence_table_with_slot_pool_core #(
	parameter int USER_COUNT = pt_pkg::USER_COUNT_DEF,
	parameter int SLOT_COUNT = pt_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // op
	input  logic [63:0] s_axis_tdata,  // user_id, server_ip
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_code, online, ip_out, zero fill
);

	import pt_pkg::*;

	localparam int USER_W = $clog2(USER_COUNT);
	localparam int SLOT_W = $clog2(SLOT_COUNT);

	pt_result_t        res;
	logic              map_we, map_re;
	logic [USER_W-1:0] map_waddr, map_raddr;
	logic [SLOT_W:0]   map_wdata, map_rdata;
	logic              ring_we, ring_re;
	logic [SLOT_W-1:0] ring_waddr, ring_raddr, ring_wdata, ring_rdata;
	logic              ip_we, ip_re;
	logic [SLOT_W-1:0] ip_waddr, ip_raddr;
	logic [31:0]       ip_wdata, ip_rdata;

	pt_ctrl #(
		.USER_COUNT(USER_COUNT),
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_op      (s_axis_tuser),
		.s_uid     (s_axis_tdata[31:0]),
		.s_ip      (s_axis_tdata[63:32]),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_res     (res),
		.map_we    (map_we),
		.map_waddr (map_waddr),
		.map_wdata (map_wdata),
		.map_re    (map_re),
		.map_raddr (map_raddr),
		.map_rdata (map_rdata),
		.ring_we   (ring_we),
		.ring_waddr(ring_waddr),
		.ring_wdata(ring_wdata),
		.ring_re   (ring_re),
		.ring_raddr(ring_raddr),
		.ring_rdata(ring_rdata),
		.ip_we     (ip_we),
		.ip_waddr  (ip_waddr),
		.ip_wdata  (ip_wdata),
		.ip_re     (ip_re),
		.ip_raddr  (ip_raddr),
		.ip_rdata  (ip_rdata)
	);

	pt_ram #(.DEPTH(USER_COUNT), .WIDTH(SLOT_W + 1)) u_user_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	pt_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_free_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	pt_ram #(.DEPTH(SLOT_COUNT), .WIDTH(32)) u_slot_ip (
		.clk  (clk),
		.we   (ip_we),
		.waddr(ip_waddr),
		.wdata(ip_wdata),
		.re   (ip_re),
		.raddr(ip_raddr),
		.rdata(ip_rdata)
	);

	assign m_axis_tdata = {4'b0000, res.ip, res.online, res.rc};

endmodule

### src/pt_checker.sv
// Port-level checks of the presence table, bound to its top level.
`include "presence_table_with_slot_pool_core_macros.svh"

module pt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	import pt_pkg::*;

	`PT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`PT_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`PT_ASSERT_IMP(a_result_reopens, $rose(m_axis_tvalid), s_axis_tready && !$past(s_axis_tready))
	`PT_ASSERT_IMP(a_fail_no_data, m_axis_tvalid && m_axis_tdata[2:0] != RC_OK, m_axis_tdata[39:3] == '0)

endmodule

bind presence_table_with_slot_pool_core pt_checker u_pt_checker (.*);
